>>> hw/rtl/ffsa_pkg.sv
// Shared types and constants for the first-fit slot allocator.
// Used by ffsa_cell and first_fit_slot_allocator_core; no dependencies.

package ffsa_pkg;

    // Default geometry of the free map.
    localparam int NUM_ZONES_DEF        = 32;
    localparam int NUM_DAYS_DEF         = 5;
    localparam int NUM_HOURS_DEF        = 5;
    localparam int FIRST_NIGHT_HOUR_DEF = 3;
    localparam int NUM_ZONE_TYPES_DEF   = 8;

    // Widths that cover the whole legal range of the geometry.
    localparam int ZONE_IDX_W = 6;   // up to 64 zones
    localparam int DAY_IDX_W  = 3;   // up to 8 days
    localparam int HOUR_IDX_W = 5;   // up to 32 hours

    // Item field widths.
    localparam int TAG_W       = 10;
    localparam int GROUP_W     = 4;
    localparam int TYPE_W      = 4;
    localparam int DAY_MASK_W  = 5;
    localparam int OUT_ZONE_W  = 5;
    localparam int OUT_DAY_W   = 3;
    localparam int OUT_HOUR_W  = 3;
    localparam int COUNT_W     = 16;

    // Eligibility registers and the configuration port.
    localparam int TYPE_REGS   = 8;
    localparam int REG_IDX_W   = 3;
    localparam int ELIG_W      = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int MAX_ZONES   = 64;
    localparam int MAX_DAYS_EXT = 8;

    // Search token that walks down the row of zone cells.
    typedef struct packed {
        logic                  active;
        logic                  found;
        logic [ZONE_IDX_W-1:0] zone;
        logic [DAY_IDX_W-1:0]  day;
        logic [HOUR_IDX_W-1:0] hour;
    } t_ffsa_tok;

endpackage

>>> hw/rtl/first_fit_slot_allocator_core.sv
// First-fit slot allocator top level: configuration registers, request
// context, a row of ffsa_cell zone cells and the result register. Uses ffsa_pkg.

// One request is handled at a time. An accepted item starts a search token
// that moves through one zone cell per clock; its result is loaded into the
// result register after the token has passed the start register and then the
// register of each zone cell. The next item is accepted once the result has
// been taken. Each cell holds the free bits of its own zone; all slots are
// free after reset. Zone types outside 1..NUM_ZONE_TYPES fail without
// touching the map. The eligibility registers (one per type, bit z enables
// zone z) sit at byte addresses 0, 4, ..., 28 and should be written only
// while no request is in progress.

module first_fit_slot_allocator_core #(
    parameter int NUM_ZONES        = ffsa_pkg::NUM_ZONES_DEF,
    parameter int NUM_DAYS         = ffsa_pkg::NUM_DAYS_DEF,
    parameter int NUM_HOURS        = ffsa_pkg::NUM_HOURS_DEF,
    parameter int FIRST_NIGHT_HOUR = ffsa_pkg::FIRST_NIGHT_HOUR_DEF,
    parameter int NUM_ZONE_TYPES   = ffsa_pkg::NUM_ZONE_TYPES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ffsa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ffsa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ffsa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Request channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ffsa_pkg::TAG_W-1:0]        i_request_tag,
    input  logic [ffsa_pkg::GROUP_W-1:0]      i_group_number,
    input  logic [ffsa_pkg::TYPE_W-1:0]       i_zone_type,
    input  logic                              i_want_daytime,
    input  logic [ffsa_pkg::DAY_MASK_W-1:0]   i_day_mask,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_booked,
    output logic [ffsa_pkg::TAG_W-1:0]        o_result_tag,
    output logic [ffsa_pkg::GROUP_W-1:0]      o_result_group,
    output logic [ffsa_pkg::OUT_ZONE_W-1:0]   o_granted_zone,
    output logic [ffsa_pkg::OUT_DAY_W-1:0]    o_granted_day,
    output logic [ffsa_pkg::OUT_HOUR_W-1:0]   o_granted_hour,
    output logic [ffsa_pkg::COUNT_W-1:0]      o_booked_count
);

    // Configuration registers.
    logic [ffsa_pkg::ELIG_W-1:0]    r_elig_regs [ffsa_pkg::TYPE_REGS];
    logic [ffsa_pkg::REG_IDX_W-1:0] w_reg_idx;
    logic                           w_cfg_wr;

    // Request context.
    logic                           r_busy;
    logic [ffsa_pkg::TAG_W-1:0]     r_req_tag;
    logic [ffsa_pkg::GROUP_W-1:0]   r_req_group;
    logic                           r_want_daytime;
    logic [ffsa_pkg::DAY_MASK_W-1:0] r_day_mask;
    logic [ffsa_pkg::ELIG_W-1:0]    r_elig;
    ffsa_pkg::t_ffsa_tok            r_start;

    // Result and count.
    logic                           r_out_valid;
    logic                           r_res_found;
    ffsa_pkg::t_ffsa_tok            r_res;
    logic [ffsa_pkg::COUNT_W-1:0]   r_count;
    logic [ffsa_pkg::COUNT_W-1:0]   n_count;

    logic                           w_in_acc;
    logic                           w_out_acc;
    logic                           w_type_ok;
    logic [ffsa_pkg::TYPE_W-1:0]    w_type_m1;
    logic [ffsa_pkg::MAX_ZONES-1:0] w_elig_ext;
    logic [ffsa_pkg::MAX_DAYS_EXT-1:0] w_day_ext;
    logic [NUM_DAYS-1:0]            w_day_en;
    ffsa_pkg::t_ffsa_tok            w_tok [NUM_ZONES+1];
    ffsa_pkg::t_ffsa_tok            w_last;
    logic [NUM_ZONES-1:0]           w_act;

    // ------------------------------------------------------------------
    // Configuration port.
    assign w_reg_idx = paddr[ffsa_pkg::REG_IDX_W+1:2];
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = r_elig_regs[w_reg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ffsa_pkg::TYPE_REGS; i++) begin
                r_elig_regs[i] <= '0;
            end
        end else if (w_cfg_wr) begin
            r_elig_regs[w_reg_idx] <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Request acceptance.
    assign o_in_stall = r_busy || r_out_valid;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;

    assign w_type_ok  = (i_zone_type >= ffsa_pkg::TYPE_W'(1)) &&
                        (i_zone_type <= ffsa_pkg::TYPE_W'(NUM_ZONE_TYPES));
    assign w_type_m1  = i_zone_type - ffsa_pkg::TYPE_W'(1);

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req_tag      <= i_request_tag;
            r_req_group    <= i_group_number;
            r_want_daytime <= i_want_daytime;
            r_day_mask     <= i_day_mask;
            // An invalid type searches with no zone enabled, so it fails.
            r_elig         <= w_type_ok ? r_elig_regs[w_type_m1[ffsa_pkg::REG_IDX_W-1:0]]
                                        : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else begin
            r_start <= '{active: w_in_acc, found: 1'b0, zone: '0, day: '0, hour: '0};
        end
    end

    // ------------------------------------------------------------------
    // Row of zone cells.
    assign w_elig_ext = ffsa_pkg::MAX_ZONES'(r_elig);
    assign w_day_ext  = ffsa_pkg::MAX_DAYS_EXT'(r_day_mask);
    assign w_day_en   = w_day_ext[NUM_DAYS-1:0];
    assign w_tok[0]   = r_start;

    for (genvar z = 0; z < NUM_ZONES; z++) begin : g_cell
        ffsa_cell #(
            .CELL_IDX         (z),
            .NUM_DAYS         (NUM_DAYS),
            .NUM_HOURS        (NUM_HOURS),
            .FIRST_NIGHT_HOUR (FIRST_NIGHT_HOUR)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_tok          (w_tok[z]),
            .i_elig         (w_elig_ext[z]),
            .i_want_daytime (r_want_daytime),
            .i_day_en       (w_day_en),
            .o_tok          (w_tok[z+1])
        );
        assign w_act[z] = w_tok[z+1].active;
    end

    assign w_last = w_tok[NUM_ZONES];

    // ------------------------------------------------------------------
    // Result capture and booking count.
    always_comb begin
        n_count = r_count;
        if (w_last.active && w_last.found && (r_count != '1)) begin
            n_count = r_count + ffsa_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_last.active) begin
                r_busy <= 1'b0;
            end
            if (w_last.active) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last.active) begin
            r_res_found <= w_last.found;
            r_res       <= w_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_booked       = r_res_found;
    assign o_result_tag   = r_req_tag;
    assign o_result_group = r_req_group;
    assign o_granted_zone = r_res.zone[ffsa_pkg::OUT_ZONE_W-1:0];
    assign o_granted_day  = r_res.day[ffsa_pkg::OUT_DAY_W-1:0];
    assign o_granted_hour = r_res.hour[ffsa_pkg::OUT_HOUR_W-1:0];
    assign o_booked_count = r_count;

`ifndef SYNTH
    // Only one search token may be in flight at any time.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_act, r_start.active}) <= 1)
        else $error("more than one search token in the cell row");

    // When new items are taken, the cell row must be empty.
    a_idle_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (w_act == '0) && !r_start.active)
        else $error("item accepted while a search is in flight");

    // A token leaving the row must find the result register free.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.active |-> !r_out_valid && r_busy)
        else $error("result arrived while the previous one is pending");

    // The booking count never goes down.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("booking count decreased");
`endif

endmodule

>>> hw/rtl/ffsa_cell.sv
// One zone of the free map: holds that zone's day x hour free bits and
// claims the first suitable slot for a passing search token. Uses ffsa_pkg.

module ffsa_cell #(
    parameter int CELL_IDX         = 0,
    parameter int NUM_DAYS         = ffsa_pkg::NUM_DAYS_DEF,
    parameter int NUM_HOURS        = ffsa_pkg::NUM_HOURS_DEF,
    parameter int FIRST_NIGHT_HOUR = ffsa_pkg::FIRST_NIGHT_HOUR_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffsa_pkg::t_ffsa_tok i_tok,
    input  logic                i_elig,
    input  logic                i_want_daytime,
    input  logic [NUM_DAYS-1:0] i_day_en,
    output ffsa_pkg::t_ffsa_tok o_tok
);

    localparam int SLOTS = NUM_DAYS * NUM_HOURS;
    localparam int NIGHT = (FIRST_NIGHT_HOUR < NUM_HOURS) ? FIRST_NIGHT_HOUR : NUM_HOURS;

    logic [SLOTS-1:0]    r_free;
    logic [SLOTS-1:0]    n_free;
    ffsa_pkg::t_ffsa_tok r_tok;
    ffsa_pkg::t_ffsa_tok n_tok;

    logic                              hit;
    logic [SLOTS-1:0]                  grab;
    logic [ffsa_pkg::DAY_IDX_W-1:0]    sel_day;
    logic [ffsa_pkg::HOUR_IDX_W-1:0]   sel_hour;
    logic                              take;

    // First free slot on an enabled day, in day order, then hour order, within the wanted half.
    always_comb begin
        hit      = 1'b0;
        grab     = '0;
        sel_day  = '0;
        sel_hour = '0;
        for (int d = 0; d < NUM_DAYS; d++) begin
            for (int h = 0; h < NUM_HOURS; h++) begin
                if (!hit && i_day_en[d] && r_free[d*NUM_HOURS+h] &&
                    (i_want_daytime ? (h < NIGHT) : (h >= NIGHT))) begin
                    hit                   = 1'b1;
                    grab[d*NUM_HOURS+h]   = 1'b1;
                    sel_day               = ffsa_pkg::DAY_IDX_W'(d);
                    sel_hour              = ffsa_pkg::HOUR_IDX_W'(h);
                end
            end
        end
    end

    assign take = i_tok.active && !i_tok.found && i_elig && hit;

    always_comb begin
        n_tok  = i_tok;
        n_free = r_free;
        if (take) begin
            n_tok.found = 1'b1;
            n_tok.zone  = ffsa_pkg::ZONE_IDX_W'(CELL_IDX);
            n_tok.day   = sel_day;
            n_tok.hour  = sel_hour;
            n_free      = r_free & ~grab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
            r_tok  <= '0;
        end else begin
            r_free <= n_free;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
